/* hw/rtl/dual_key_sorted_slot_table_defines.svh */
// Assertion macros used by the slot table datapath.
`ifndef DUAL_KEY_SORTED_SLOT_TABLE_DEFINES_SVH
`define DUAL_KEY_SORTED_SLOT_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DKST_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("slot table assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DKST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("slot table assertion failed");

`endif

/* hw/rtl/dkst_pkg.sv */
// Shared types, codes and helpers of the dual key sorted slot table.
package dkst_pkg;

    localparam int MAX_USERS_DEF  = 1024;
    localparam int NAME_BYTES_DEF = 8;
    localparam int NAME_W         = 64;
    localparam int NUM_W          = 31;
    localparam int SLOT_OUT_W     = 10;
    localparam int POS_OUT_W      = 11;

    typedef enum logic [1:0] {
        FN_LOOKUP_NAME = 2'd0,
        FN_LOOKUP_NUM  = 2'd1,
        FN_INSERT      = 2'd2,
        FN_DELETE      = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_NOT_FOUND    = 3'd1,
        ST_NAME_TAKEN   = 3'd2,
        ST_NUMBER_TAKEN = 3'd3,
        ST_FULL         = 3'd4
    } t_status;

    // Source of the key for a new search.
    typedef enum logic [1:0] {
        SK_NAME,
        SK_NUM,
        SK_DEL
    } t_skey;

    // Kind of result to form.
    typedef enum logic [2:0] {
        RES_LOOKUP,
        RES_FULL,
        RES_NUM_ZERO,
        RES_NAME_TAKEN,
        RES_NUM_TAKEN,
        RES_INS_OK,
        RES_DEL_OK
    } t_res;

    typedef struct packed {
        logic [1:0]        func;
        logic [NAME_W-1:0] name_key;
        logic [NUM_W-1:0]  user_number;
    } t_in_item;

    typedef struct packed {
        logic                  found;
        logic [2:0]            status;
        logic [SLOT_OUT_W-1:0] slot;
        logic [POS_OUT_W-1:0]  index_position;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  load;
        logic  srch_start;
        t_skey skey;
        logic  rd_lo;
        logic  step;
        logic  cap_slot;
        logic  final_cmp;
        logic  miss;
        logic  save_npos;
        logic  save_mpos;
        logic  save_dslot;
        logic  save_nhit;
        logic  key_rd_slot;
        logic  alloc;
        logic  pop_free;
        logic  push_free;
        logic  shift_ins;
        logic  shift_rem;
        logic  shift_issue;
        logic  cnt_inc;
        logic  cnt_dec;
        logic  set_res;
        t_res  res_kind;
        logic  emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_func func;
        logic  full;
        logic  num_zero;
        logic  lo_lt_hi;
        logic  lo_lt_cnt;
        logic  hit;
        logic  shift_more;
        logic  out_free;
    } t_stat;

    // Keep the leading nbytes bytes up to the first zero byte; clear the rest.
    function automatic logic [NAME_W-1:0] canon_name(input logic [NAME_W-1:0] k,
                                                    input int nbytes);
        logic [NAME_W-1:0] r;
        logic              stop;
        logic [7:0]        b;
        r    = '0;
        stop = 1'b0;
        for (int i = 0; i < 8; i++) begin
            b = k[NAME_W-1-8*i -: 8];
            if (i >= nbytes || b == 8'd0) begin
                stop = 1'b1;
            end
            if (!stop) begin
                r[NAME_W-1-8*i -: 8] = b;
            end
        end
        return r;
    endfunction

endpackage

/* hw/rtl/dkst_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module dkst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/dkst_ctrl.sv */
// Controller state machine of the slot table: sequences searches, updates and results.
module dkst_ctrl
    import dkst_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SA,
        S_SB,
        S_SC,
        S_SFB,
        S_SFC,
        S_SEND,
        S_DEL_KEY,
        S_INS_ALLOC,
        S_INS_POP,
        S_DEL_UPD,
        S_SHIFT,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        PH_LOOKUP,
        PH_INS_NAME,
        PH_INS_NUM,
        PH_DEL_NAME,
        PH_DEL_NUM
    } t_phase;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic   r_in_ready, n_in_ready;

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && r_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end else begin
                    n_in_ready = 1'b1;
                end
            end
            S_DISPATCH: begin
                unique case (i_stat.func)
                    FN_LOOKUP_NAME: begin
                        o_cmd.srch_start = 1'b1;
                        o_cmd.skey       = SK_NAME;
                        n_phase          = PH_LOOKUP;
                        n_state          = S_SA;
                    end
                    FN_LOOKUP_NUM: begin
                        o_cmd.srch_start = 1'b1;
                        o_cmd.skey       = SK_NUM;
                        n_phase          = PH_LOOKUP;
                        n_state          = S_SA;
                    end
                    FN_INSERT: begin
                        if (i_stat.full) begin
                            o_cmd.set_res  = 1'b1;
                            o_cmd.res_kind = RES_FULL;
                            n_state        = S_DONE;
                        end else if (i_stat.num_zero) begin
                            o_cmd.set_res  = 1'b1;
                            o_cmd.res_kind = RES_NUM_ZERO;
                            n_state        = S_DONE;
                        end else begin
                            o_cmd.srch_start = 1'b1;
                            o_cmd.skey       = SK_NAME;
                            n_phase          = PH_INS_NAME;
                            n_state          = S_SA;
                        end
                    end
                    FN_DELETE: begin
                        o_cmd.srch_start = 1'b1;
                        o_cmd.skey       = SK_NAME;
                        n_phase          = PH_DEL_NAME;
                        n_state          = S_SA;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            // One bisection step: order read, key read, compare.
            S_SA: begin
                if (i_stat.lo_lt_hi) begin
                    n_state = S_SB;
                end else if (i_stat.lo_lt_cnt) begin
                    o_cmd.rd_lo = 1'b1;
                    n_state     = S_SFB;
                end else begin
                    o_cmd.miss = 1'b1;
                    n_state    = S_SEND;
                end
            end
            S_SB: n_state = S_SC;
            S_SC: begin
                o_cmd.step = 1'b1;
                n_state    = S_SA;
            end
            // Check the entry at the final position.
            S_SFB: begin
                o_cmd.cap_slot = 1'b1;
                n_state        = S_SFC;
            end
            S_SFC: begin
                o_cmd.final_cmp = 1'b1;
                n_state         = S_SEND;
            end
            S_SEND: begin
                unique case (r_phase)
                    PH_LOOKUP: begin
                        o_cmd.set_res  = 1'b1;
                        o_cmd.res_kind = RES_LOOKUP;
                        n_state        = S_DONE;
                    end
                    PH_INS_NAME: begin
                        o_cmd.save_npos = 1'b1;
                        if (i_stat.hit) begin
                            o_cmd.set_res  = 1'b1;
                            o_cmd.res_kind = RES_NAME_TAKEN;
                            n_state        = S_DONE;
                        end else begin
                            o_cmd.srch_start = 1'b1;
                            o_cmd.skey       = SK_NUM;
                            n_phase          = PH_INS_NUM;
                            n_state          = S_SA;
                        end
                    end
                    PH_INS_NUM: begin
                        o_cmd.save_mpos = 1'b1;
                        if (i_stat.hit) begin
                            o_cmd.set_res  = 1'b1;
                            o_cmd.res_kind = RES_NUM_TAKEN;
                            n_state        = S_DONE;
                        end else begin
                            n_state = S_INS_ALLOC;
                        end
                    end
                    PH_DEL_NAME: begin
                        o_cmd.save_npos = 1'b1;
                        if (i_stat.hit) begin
                            o_cmd.save_dslot   = 1'b1;
                            o_cmd.key_rd_slot  = 1'b1;
                            n_state            = S_DEL_KEY;
                        end else begin
                            o_cmd.set_res  = 1'b1;
                            o_cmd.res_kind = RES_LOOKUP;
                            n_state        = S_DONE;
                        end
                    end
                    PH_DEL_NUM: begin
                        o_cmd.save_mpos = 1'b1;
                        o_cmd.save_nhit = 1'b1;
                        n_state         = S_DEL_UPD;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_DEL_KEY: begin
                o_cmd.srch_start = 1'b1;
                o_cmd.skey       = SK_DEL;
                n_phase          = PH_DEL_NUM;
                n_state          = S_SA;
            end
            S_INS_ALLOC: begin
                o_cmd.alloc = 1'b1;
                n_state     = S_INS_POP;
            end
            S_INS_POP: begin
                o_cmd.pop_free  = 1'b1;
                o_cmd.shift_ins = 1'b1;
                n_state         = S_SHIFT;
            end
            S_DEL_UPD: begin
                o_cmd.push_free = 1'b1;
                o_cmd.shift_rem = 1'b1;
                n_state         = S_SHIFT;
            end
            // Move index entries one per cycle.
            S_SHIFT: begin
                if (i_stat.shift_more) begin
                    o_cmd.shift_issue = 1'b1;
                end else begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                o_cmd.set_res = 1'b1;
                if (r_phase == PH_INS_NUM) begin
                    o_cmd.cnt_inc  = 1'b1;
                    o_cmd.res_kind = RES_INS_OK;
                end else begin
                    o_cmd.cnt_dec  = 1'b1;
                    o_cmd.res_kind = RES_DEL_OK;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                    n_in_ready = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_phase    <= PH_LOOKUP;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_in_ready <= n_in_ready;
        end
    end

    assign o_in_ready = r_in_ready;

endmodule

/* hw/rtl/dkst_dp.sv */
// Datapath of the slot table: index and key memories, search and shift logic, result register.
`include "dual_key_sorted_slot_table_defines.svh"
module dkst_dp
    import dkst_pkg::*;
#(
    parameter int MAX_USERS  = MAX_USERS_DEF,
    parameter int NAME_BYTES = NAME_BYTES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_data,
    input  t_cmd      i_cmd,
    output t_stat     o_stat,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int SW = $clog2(MAX_USERS);
    localparam int CW = $clog2(MAX_USERS + 1);
    localparam logic [CW-1:0] MaxCnt = CW'(MAX_USERS);

    // Request and search registers.
    t_func             r_func;
    logic [NAME_W-1:0] r_name;
    logic [NUM_W-1:0]  r_num;
    logic [CW-1:0]     r_lo, r_hi;
    logic              r_by_name;
    logic [NAME_W-1:0] r_skey;
    logic              r_hit;
    logic [SW-1:0]     r_slot;
    logic [CW-1:0]     r_npos, r_mpos;
    logic [SW-1:0]     r_dslot;
    logic              r_nhit;
    logic [SW-1:0]     r_avail;
    logic [CW-1:0]     r_free_head;
    logic [CW-1:0]     r_cnt;
    logic [CW-1:0]     r_i;
    logic              r_sh_ins;
    logic              r_sh_act;
    logic              r_wv;
    logic [CW-1:0]     r_wi;
    t_out_item         r_res;
    logic              r_out_valid;
    t_out_item         r_out;

    // Memory read data.
    logic [SW-1:0]     name_ord_rd, num_ord_rd;
    logic [NAME_W-1:0] name_rd;
    logic [NUM_W-1:0]  numk_rd;
    logic [CW-1:0]     nfree_rd;

    logic [CW-1:0]     mid, avail_c, lo_min_ins, lo_min_rem, sh_addr, ord_addr;
    logic              full, out_free, sh_last;
    logic [NAME_W-1:0] cmp_val;
    logic [SW-1:0]     num_raddr;
    logic              name_ord_we, num_ord_we;
    logic [SW-1:0]     name_ord_wd, num_ord_wd;

    // Search arithmetic and slot allocation.
    assign mid        = r_lo + ((r_hi - r_lo) >> 1);
    assign avail_c    = (r_free_head != '0) ? (r_free_head - CW'(1)) : r_cnt;
    assign full       = (avail_c >= MaxCnt) || (r_cnt >= MaxCnt);
    assign out_free   = !r_out_valid || i_out_ready;
    assign cmp_val    = r_by_name ? name_rd : {{(NAME_W-NUM_W){1'b0}}, numk_rd};
    assign lo_min_ins = (r_npos < r_mpos) ? r_npos : r_mpos;
    assign lo_min_rem = r_nhit ? lo_min_ins : r_npos;

    // Shift address: insert moves entries up from the top, delete moves them down.
    always_comb begin
        if (r_sh_ins) begin
            sh_addr = (r_i == '0) ? '0 : (r_i - CW'(1));
            sh_last = (r_i == lo_min_ins);
        end else begin
            sh_addr = r_i + CW'(1);
            sh_last = ({1'b0, r_i} + (CW+1)'(2)) >= {1'b0, r_cnt};
        end
        ord_addr = i_cmd.shift_issue ? sh_addr : (i_cmd.rd_lo ? r_lo : mid);
    end

    assign num_raddr = i_cmd.key_rd_slot ? r_slot : num_ord_rd;

    // Index write stage, in the cycle after the read of the moved entry is issued.
    assign name_ord_we = r_wv && (r_wi >= r_npos);
    assign name_ord_wd = (r_sh_ins && r_wi == r_npos) ? r_avail : name_ord_rd;
    assign num_ord_we  = r_wv && (r_wi >= r_mpos) && (r_sh_ins || r_nhit);
    assign num_ord_wd  = (r_sh_ins && r_wi == r_mpos) ? r_avail : num_ord_rd;

    dkst_ram #(.WIDTH(SW), .DEPTH(MAX_USERS)) u_name_order (
        .i_clk   (i_clk),
        .i_we    (name_ord_we),
        .i_waddr (r_wi[SW-1:0]),
        .i_wdata (name_ord_wd),
        .i_raddr (ord_addr[SW-1:0]),
        .o_rdata (name_ord_rd)
    );

    dkst_ram #(.WIDTH(SW), .DEPTH(MAX_USERS)) u_number_order (
        .i_clk   (i_clk),
        .i_we    (num_ord_we),
        .i_waddr (r_wi[SW-1:0]),
        .i_wdata (num_ord_wd),
        .i_raddr (ord_addr[SW-1:0]),
        .o_rdata (num_ord_rd)
    );

    dkst_ram #(.WIDTH(NAME_W), .DEPTH(MAX_USERS)) u_slot_name (
        .i_clk   (i_clk),
        .i_we    (i_cmd.alloc),
        .i_waddr (avail_c[SW-1:0]),
        .i_wdata (r_name),
        .i_raddr (name_ord_rd),
        .o_rdata (name_rd)
    );

    dkst_ram #(.WIDTH(NUM_W), .DEPTH(MAX_USERS)) u_slot_number (
        .i_clk   (i_clk),
        .i_we    (i_cmd.alloc),
        .i_waddr (avail_c[SW-1:0]),
        .i_wdata (r_num),
        .i_raddr (num_raddr),
        .o_rdata (numk_rd)
    );

    dkst_ram #(.WIDTH(CW), .DEPTH(MAX_USERS)) u_next_free (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push_free),
        .i_waddr (r_dslot),
        .i_wdata (r_free_head),
        .i_raddr (avail_c[SW-1:0]),
        .o_rdata (nfree_rd)
    );

    // Control state: counts, free list head, shift sequencing, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_free_head <= '0;
            r_sh_act    <= 1'b0;
            r_wv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wv <= i_cmd.shift_issue;
            if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_cnt <= r_cnt - CW'(1);
            end
            if (i_cmd.pop_free && r_free_head != '0) begin
                r_free_head <= nfree_rd;
            end else if (i_cmd.push_free) begin
                r_free_head <= CW'(r_dslot) + CW'(1);
            end
            if (i_cmd.shift_ins) begin
                r_sh_act <= 1'b1;
            end else if (i_cmd.shift_rem) begin
                r_sh_act <= ({1'b0, lo_min_rem} + (CW+1)'(1)) < {1'b0, r_cnt};
            end else if (i_cmd.shift_issue && sh_last) begin
                r_sh_act <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= t_func'(i_in_data.func);
            r_name <= canon_name(i_in_data.name_key, NAME_BYTES);
            r_num  <= i_in_data.user_number;
        end
        if (i_cmd.srch_start) begin
            r_lo <= '0;
            r_hi <= r_cnt;
            case (i_cmd.skey)
                SK_NAME: begin
                    r_by_name <= 1'b1;
                    r_skey    <= r_name;
                end
                SK_NUM: begin
                    r_by_name <= 1'b0;
                    r_skey    <= {{(NAME_W-NUM_W){1'b0}}, r_num};
                end
                default: begin
                    r_by_name <= 1'b0;
                    r_skey    <= {{(NAME_W-NUM_W){1'b0}}, numk_rd};
                end
            endcase
        end
        if (i_cmd.step) begin
            if (cmp_val < r_skey) begin
                r_lo <= mid + CW'(1);
            end else begin
                r_hi <= mid;
            end
        end
        if (i_cmd.cap_slot) begin
            r_slot <= r_by_name ? name_ord_rd : num_ord_rd;
        end
        if (i_cmd.final_cmp) begin
            r_hit <= (cmp_val == r_skey);
            if (cmp_val != r_skey) begin
                r_slot <= '0;
            end
        end
        if (i_cmd.miss) begin
            r_hit  <= 1'b0;
            r_slot <= '0;
        end
        if (i_cmd.save_npos) begin
            r_npos <= r_lo;
        end
        if (i_cmd.save_mpos) begin
            r_mpos <= r_lo;
        end
        if (i_cmd.save_dslot) begin
            r_dslot <= r_slot;
        end
        if (i_cmd.save_nhit) begin
            r_nhit <= r_hit && (r_slot == r_dslot);
        end
        if (i_cmd.alloc) begin
            r_avail <= avail_c[SW-1:0];
        end
        if (i_cmd.shift_ins) begin
            r_sh_ins <= 1'b1;
            r_i      <= r_cnt;
        end else if (i_cmd.shift_rem) begin
            r_sh_ins <= 1'b0;
            r_i      <= lo_min_rem;
        end else if (i_cmd.shift_issue && !sh_last) begin
            r_i <= r_sh_ins ? (r_i - CW'(1)) : (r_i + CW'(1));
        end
        if (i_cmd.shift_issue) begin
            r_wi <= r_i;
        end
        if (i_cmd.set_res) begin
            case (i_cmd.res_kind)
                RES_LOOKUP: begin
                    r_res.found          <= r_hit;
                    r_res.status         <= r_hit ? ST_OK : ST_NOT_FOUND;
                    r_res.slot           <= SLOT_OUT_W'(r_slot);
                    r_res.index_position <= POS_OUT_W'(r_lo);
                end
                RES_NAME_TAKEN: begin
                    r_res.found          <= 1'b1;
                    r_res.status         <= ST_NAME_TAKEN;
                    r_res.slot           <= SLOT_OUT_W'(r_slot);
                    r_res.index_position <= POS_OUT_W'(r_lo);
                end
                RES_NUM_TAKEN: begin
                    r_res.found          <= 1'b1;
                    r_res.status         <= ST_NUMBER_TAKEN;
                    r_res.slot           <= SLOT_OUT_W'(r_slot);
                    r_res.index_position <= POS_OUT_W'(r_lo);
                end
                RES_INS_OK: begin
                    r_res.found          <= 1'b0;
                    r_res.status         <= ST_OK;
                    r_res.slot           <= SLOT_OUT_W'(r_avail);
                    r_res.index_position <= POS_OUT_W'(r_npos);
                end
                RES_DEL_OK: begin
                    r_res.found          <= 1'b1;
                    r_res.status         <= ST_OK;
                    r_res.slot           <= SLOT_OUT_W'(r_dslot);
                    r_res.index_position <= POS_OUT_W'(r_npos);
                end
                RES_NUM_ZERO: begin
                    r_res.found          <= 1'b0;
                    r_res.status         <= ST_NUMBER_TAKEN;
                    r_res.slot           <= '0;
                    r_res.index_position <= '0;
                end
                default: begin
                    r_res.found          <= 1'b0;
                    r_res.status         <= ST_FULL;
                    r_res.slot           <= '0;
                    r_res.index_position <= '0;
                end
            endcase
        end
        if (i_cmd.emit) begin
            r_out <= r_res;
        end
    end

    // Status to the controller.
    always_comb begin
        o_stat            = '0;
        o_stat.func       = r_func;
        o_stat.full       = full;
        o_stat.num_zero   = (r_num == '0);
        o_stat.lo_lt_hi   = (r_lo < r_hi);
        o_stat.lo_lt_cnt  = (r_lo < r_cnt);
        o_stat.hit        = r_hit;
        o_stat.shift_more = r_sh_act;
        o_stat.out_free   = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The entry count never passes the table size.
    `DKST_ASSERT_IMPL(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= MaxCnt)
    // Index writes stay inside the table.
    `DKST_ASSERT_IMPL(a_wr_range, i_clk, i_rst_n, r_wv, r_wi < MaxCnt)
    // A result is only loaded when the output register can take it.
    `DKST_ASSERT_IMPL(a_emit_free, i_clk, i_rst_n, i_cmd.emit, out_free)
    // A loaded result shows as valid on the next cycle.
    `DKST_ASSERT_NEXT(a_emit_valid, i_clk, i_rst_n, i_cmd.emit, r_out_valid)

endmodule

/* hw/rtl/dual_key_sorted_slot_table.sv */
// Top level of the dual key sorted slot table: controller plus datapath.
// Handles one item at a time; a new item is taken while the previous result waits in
// the output register. Lookups run a bisection of the index, each step an order read,
// a key read and a compare. Insert runs a name search and, if the name is free, a
// number search, then moves index entries one per cycle through the order memories'
// single ports, from the top down to the lower splice position; delete runs a name
// search and, on a hit, a number search, and moves entries from the lower removal
// position to the end. There is no clearing pass.
module dual_key_sorted_slot_table
    import dkst_pkg::*;
#(
    parameter int MAX_USERS  = MAX_USERS_DEF,
    parameter int NAME_BYTES = NAME_BYTES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_cmd  cmd;
    t_stat stat;

    // Sequencer.
    dkst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Memories, search and result path.
    dkst_dp #(
        .MAX_USERS  (MAX_USERS),
        .NAME_BYTES (NAME_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the dual key sorted slot table.
`timescale 1ns / 100ps

module tb_top;
    import dkst_pkg::*;

    localparam int USERS = 1024;
    localparam int NBYTES = 8;
    localparam int STALL_LIMIT = 20000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;

    dual_key_sorted_slot_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Clock with a 4 ns period.
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Shadow copy of the table state.
    logic [9:0]  by_name_idx [USERS];
    logic [9:0]  by_num_idx [USERS];
    logic [63:0] stored_name [USERS];
    logic [30:0] stored_num [USERS];
    logic [10:0] next_free [USERS];
    int unsigned free_top;
    int unsigned n_users;

    t_out_item pending_results[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned items_sent;
    int unsigned idle_cycles;
    bit          sender_done;

    // Names and numbers ever inserted, kept so random requests can hit stored entries.
    logic [63:0] live_names[$];
    logic [30:0] live_nums[$];

    function automatic logic [63:0] trim_name(input logic [63:0] k);
        logic [63:0] r;
        bit stop;
        r = '0;
        stop = 0;
        for (int i = 0; i < 8; i++) begin
            if (i >= NBYTES || k[63-8*i -: 8] == 8'd0) stop = 1;
            if (!stop) r[63-8*i -: 8] = k[63-8*i -: 8];
        end
        return r;
    endfunction

    // Lower-bound search of one index over the shadow state.
    function automatic int unsigned bisect(input bit on_name, input logic [63:0] key,
                                           output bit hit, output int unsigned hit_slot);
        int unsigned lo, hi, mid, s;
        logic [63:0] v;
        lo = 0;
        hi = n_users;
        while (lo < hi) begin
            mid = lo + ((hi - lo) >> 1);
            s = on_name ? int'(by_name_idx[mid]) : int'(by_num_idx[mid]);
            v = on_name ? stored_name[s] : {33'd0, stored_num[s]};
            if (v < key) lo = mid + 1;
            else hi = mid;
        end
        hit = 0;
        hit_slot = 0;
        if (lo < n_users) begin
            s = on_name ? int'(by_name_idx[lo]) : int'(by_num_idx[lo]);
            v = on_name ? stored_name[s] : {33'd0, stored_num[s]};
            if (v == key) begin
                hit = 1;
                hit_slot = s;
            end
        end
        return lo;
    endfunction

    // Applies one request to the shadow table and returns its result.
    function automatic t_out_item apply_request(input t_in_item req);
        t_out_item r;
        logic [63:0] nm;
        int unsigned avail, npos, mpos, hs, ns, i;
        bit hit, nhit;
        nm = trim_name(req.name_key);
        r = '0;
        r.status = ST_OK;
        case (t_func'(req.func))
            FN_LOOKUP_NAME, FN_LOOKUP_NUM: begin
                npos = bisect(req.func == FN_LOOKUP_NAME,
                    req.func == FN_LOOKUP_NAME ? nm : {33'd0, req.user_number}, hit, hs);
                r.index_position = 11'(npos);
                r.found = hit;
                r.slot = 10'(hs);
                r.status = hit ? ST_OK : ST_NOT_FOUND;
            end
            FN_INSERT: begin
                avail = free_top != 0 ? free_top - 1 : n_users;
                if (avail >= USERS || n_users >= USERS) begin
                    r.status = ST_FULL;
                end else if (req.user_number == 0) begin
                    r.status = ST_NUMBER_TAKEN;
                end else begin
                    npos = bisect(1, nm, hit, hs);
                    if (hit) begin
                        r.found = 1;
                        r.status = ST_NAME_TAKEN;
                        r.slot = 10'(hs);
                        r.index_position = 11'(npos);
                    end else begin
                        mpos = bisect(0, {33'd0, req.user_number}, hit, hs);
                        if (hit) begin
                            r.found = 1;
                            r.status = ST_NUMBER_TAKEN;
                            r.slot = 10'(hs);
                            r.index_position = 11'(mpos);
                        end else begin
                            if (free_top != 0) free_top = int'(next_free[avail]);
                            stored_name[avail] = nm;
                            stored_num[avail] = req.user_number;
                            for (i = n_users; i > npos; i--) by_name_idx[i] = by_name_idx[i-1];
                            by_name_idx[npos] = 10'(avail);
                            for (i = n_users; i > mpos; i--) by_num_idx[i] = by_num_idx[i-1];
                            by_num_idx[mpos] = 10'(avail);
                            n_users++;
                            r.slot = 10'(avail);
                            r.index_position = 11'(npos);
                            live_names.push_back(nm);
                            live_nums.push_back(req.user_number);
                        end
                    end
                end
            end
            default: begin
                npos = bisect(1, nm, hit, hs);
                r.index_position = 11'(npos);
                if (!hit) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    mpos = bisect(0, {33'd0, stored_num[hs]}, nhit, ns);
                    r.found = 1;
                    r.slot = 10'(hs);
                    for (i = npos; i + 1 < n_users; i++) by_name_idx[i] = by_name_idx[i+1];
                    if (nhit && ns == hs)
                        for (i = mpos; i + 1 < n_users; i++) by_num_idx[i] = by_num_idx[i+1];
                    n_users--;
                    next_free[hs] = 11'(free_top);
                    free_top = hs + 1;
                    stored_name[hs] = '0;
                    stored_num[hs] = '0;
                end
            end
        endcase
        return r;
    endfunction

    // Sends one item after a random gap and records its expected result.
    task automatic send_item(input t_func f, input logic [63:0] nm, input logic [30:0] num);
        t_in_item    req;
        int unsigned gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req.func = f;
        req.name_key = nm;
        req.user_number = num;
        i_in_data <= req;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(apply_request(req));
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
    endtask

    // Result checker; the receiver stalls at random before taking each item.
    initial begin
        t_out_item want;
        int unsigned stall;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 8);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_out_data);
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.found !== want.found || o_out_data.status !== want.status
                    || o_out_data.slot !== want.slot
                    || o_out_data.index_position !== want.index_position) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, o_out_data);
                end
            end
        end
    end

    // Watchdog on cycles without any accepted item.
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles = 0;
            else if (pending_results.size() != 0 || !sender_done) idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic logic [63:0] rand_name();
        logic [63:0] k;
        k = {$urandom(), $urandom()};
        case ($urandom_range(0, 3))
            0: k[$urandom_range(0, 7)*8 +: 8] = 8'd0;
            1: k = k & 64'hFFFF_0000_0000_0000;
            default: ;
        endcase
        return k;
    endfunction

    // Directed: extremes, every operation, and the special cases but a full table.
    task automatic test_directed();
        send_item(FN_LOOKUP_NAME, 64'd0, 31'd0);
        send_item(FN_LOOKUP_NUM, 64'd0, 31'd0);
        send_item(FN_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 31'd5);
        send_item(FN_INSERT, 64'h4100_0000_0000_0000, 31'd0);
        send_item(FN_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 31'h7FFF_FFFF);
        send_item(FN_INSERT, 64'h4142_0043_4400_0000, 31'd1);
        send_item(FN_INSERT, 64'h4142_0000_0000_0000, 31'd2);
        send_item(FN_INSERT, 64'h4300_0000_0000_0000, 31'd1);
        send_item(FN_INSERT, 64'h0055_6677_8899_AABB, 31'd3);
        send_item(FN_LOOKUP_NAME, 64'h4142_00FF_FFFF_FFFF, 31'd0);
        send_item(FN_LOOKUP_NAME, 64'h4142_4300_0000_0000, 31'd0);
        send_item(FN_LOOKUP_NUM, 64'd0, 31'h7FFF_FFFF);
        send_item(FN_LOOKUP_NUM, 64'd0, 31'd0);
        send_item(FN_LOOKUP_NUM, 64'd0, 31'd7);
        send_item(FN_DELETE, 64'h4142_0000_0000_0000, 31'd0);
        send_item(FN_DELETE, 64'h4142_0000_0000_0000, 31'd0);
        send_item(FN_INSERT, 64'h5A00_0000_0000_0000, 31'h4000_0000);
        send_item(FN_LOOKUP_NAME, 64'd0, 31'd0);
        send_item(FN_DELETE, 64'd0, 31'd0);
        send_item(FN_INSERT, 64'h0000_0000_0000_0001, 31'd9);
        wait_drained();
    endtask

    // Grows the table with a burst of inserts, then frees some slots.
    task automatic test_bulk_fill();
        for (int i = 0; i < 160; i++)
            send_item(FN_INSERT, {$urandom(), $urandom()} | 64'h0101_0101_0101_0101,
                      31'($urandom()) | 31'h1);
        send_item(FN_LOOKUP_NAME, live_names[live_names.size()-1], 31'd0);
        wait_drained();
        for (int i = 0; i < 40; i++) send_item(FN_DELETE, live_names[$urandom_range(0, live_names.size()-1)], 31'd0);
        wait_drained();
    endtask

    // Random mix, biased toward keys already in the table.
    task automatic test_random(input int unsigned count);
        t_func f;
        logic [63:0] nm;
        logic [30:0] num;
        for (int unsigned n = 0; n < count; n++) begin
            f = t_func'($urandom_range(0, 3));
            nm = rand_name();
            num = 31'($urandom());
            if ($urandom_range(0, 9) == 0) num = 31'($urandom_range(0, 3));
            if (live_names.size() != 0 && $urandom_range(0, 1)) begin
                nm = live_names[$urandom_range(0, live_names.size()-1)];
                num = live_nums[$urandom_range(0, live_nums.size()-1)];
                if ($urandom_range(0, 1)) num = 31'($urandom()) | 31'h1;
            end
            send_item(f, nm, num);
            if (n == count / 2) wait_drained();
        end
    endtask

    initial begin
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        sender_done = 0;
        free_top = 0;
        n_users = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(160);
        test_bulk_fill();
        test_random(160);
        sender_done = 1;
        wait_drained();
        repeat (1200) @(negedge i_clk);
        $display("Ran %0d requests and checked %0d results, including a bulk fill,",
                 items_sent, results_seen);
        $display("deletes with slot reuse from the free list and the rejection codes.");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/dkst_pkg.sv
hw/rtl/dkst_ram.sv
hw/rtl/dkst_ctrl.sv
hw/rtl/dkst_dp.sv
hw/rtl/dual_key_sorted_slot_table.sv
verif/tb_top.sv
